### hdl/cfre_pkg.sv
// Shared types, constants and command/status structs for the frame receiver.
`default_nettype none

package cfre_pkg;

    localparam int STORE_DEPTH_DEF = 16;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] END_BYTE      = 8'hFD;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_ADDR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE       = 2'd2;

    localparam logic [7:0] CONTROLLER_ADDR_RST = 8'hE0;
    localparam logic [7:0] RADIO_ADDR_RST      = 8'h56;
    localparam logic [7:0] NACK_CODE_RST       = 8'hFA;

    localparam int LEN_W = 5;

    typedef logic [7:0] byte_t;

    // Frame kind codes on the output
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_NACK = 1'b1;

    typedef struct packed {
        logic store_byte;   // write the accepted byte into the body store
        logic start_emit;   // rewind the output sequencer
        logic emit_en;      // sequencer may load output bytes
        logic emit_kind;    // KIND_ECHO or KIND_NACK
        logic clear_count;  // drop the stored body count
    } cfre_cmd_t;

    typedef struct packed {
        logic is_preamble;  // input byte is the preamble
        logic is_end;       // input byte is the end byte
        logic store_full;   // body store holds STORE_DEPTH bytes
        logic last_load;    // final byte of a frame loads this cycle
    } cfre_status_t;

endpackage

`default_nettype wire

### hdl/cfre_if.sv
// Valid/ready channel interfaces for received bytes, transmitted bytes and config writes.
`default_nettype none

interface cfre_rx_if;
    import cfre_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfre_tx_if;
    import cfre_pkg::*;
    logic             valid;
    logic             ready;
    byte_t            tx_byte;
    logic             frame_kind;
    logic [LEN_W-1:0] body_length;
    logic             last_byte;
    modport source (output valid, output tx_byte, output frame_kind,
                    output body_length, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input frame_kind,
                    input body_length, input last_byte, output ready);
endinterface

interface cfre_cfg_if;
    import cfre_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    byte_t                data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/cfre_ctrl.sv
// Receive and emit state machine of the frame receiver.
`default_nettype none

module cfre_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   rx_valid,
    output logic                  rx_ready,
    input  cfre_pkg::cfre_status_t status,
    output cfre_pkg::cfre_cmd_t   cmd
);
    import cfre_pkg::*;

    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_SECOND = 3'd1;
    localparam logic [2:0] ST_BODY   = 3'd2;
    localparam logic [2:0] ST_NACK   = 3'd3;
    localparam logic [2:0] ST_ECHO   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rx_xfer;

    assign rx_ready = (state_reg == ST_WAIT) || (state_reg == ST_SECOND)
                   || (state_reg == ST_BODY);
    assign rx_xfer  = rx_valid && rx_ready;

    // Decide next state and drive datapath commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_kind   = KIND_ECHO;
        case (state_reg)
            ST_WAIT:
            begin
                if (rx_xfer && status.is_preamble)
                    state_next = ST_SECOND;
            end
            ST_SECOND:
            begin
                if (rx_xfer)
                begin
                    if (status.is_preamble)
                        state_next = ST_BODY;
                    else
                    begin
                        state_next     = ST_NACK;
                        cmd.start_emit = 1'b1;
                    end
                end
            end
            ST_BODY:
            begin
                if (rx_xfer)
                begin
                    if (status.is_end)
                    begin
                        state_next     = ST_ECHO;
                        cmd.start_emit = 1'b1;
                    end
                    else if (!status.store_full)
                        cmd.store_byte = 1'b1;
                    else
                    begin
                        state_next     = ST_NACK;
                        cmd.start_emit = 1'b1;
                    end
                end
            end
            ST_NACK, ST_ECHO:
            begin
                cmd.emit_en   = 1'b1;
                cmd.emit_kind = (state_reg == ST_NACK) ? KIND_NACK : KIND_ECHO;
                if (status.last_load)
                begin
                    state_next      = ST_WAIT;
                    cmd.clear_count = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### hdl/cfre_datapath.sv
// Body store, config registers, output sequencer and output register.
`default_nettype none

module cfre_datapath #(
    parameter int STORE_DEPTH = cfre_pkg::STORE_DEPTH_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  cfre_pkg::byte_t                rx_byte,
    input  wire                            cfg_we,
    input  wire [cfre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  cfre_pkg::byte_t                cfg_data,
    input  cfre_pkg::cfre_cmd_t            cmd,
    output cfre_pkg::cfre_status_t         status,
    input  wire                            tx_ready,
    output logic                           tx_valid,
    output cfre_pkg::byte_t                tx_byte,
    output logic                           frame_kind,
    output logic [cfre_pkg::LEN_W-1:0]     body_length,
    output logic                           last_byte
);
    import cfre_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int POS_W = $clog2(STORE_DEPTH + 3);

    // Positions within a NACK frame
    localparam logic [POS_W-1:0] POS_PRE0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PRE1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CTRL = POS_W'(2);
    localparam logic [POS_W-1:0] POS_RIG  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CODE = POS_W'(4);
    localparam logic [POS_W-1:0] POS_NEND = POS_W'(5);

    byte_t              mem [STORE_DEPTH];
    byte_t              rd_data_reg;
    logic               rd_valid_reg;
    logic [CNT_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [POS_W-1:0]   pos_reg;
    byte_t              ctrl_addr_reg;
    byte_t              radio_addr_reg;
    byte_t              nack_code_reg;

    logic               out_valid_reg;
    byte_t              out_byte_reg;
    logic               out_kind_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_last_reg;

    logic [POS_W-1:0]   echo_end_pos;
    logic [CNT_W+LEN_W-1:0] len_wide;
    logic [LEN_W-1:0]   len_masked;
    logic               out_free;
    logic               avail;
    logic               is_last;
    logic               is_body;
    logic               load;
    byte_t              sel_byte;

    assign echo_end_pos = POS_W'(count_reg) + POS_W'(2);
    assign len_wide     = {{LEN_W{1'b0}}, count_reg};
    assign len_masked   = len_wide[LEN_W-1:0];
    assign out_free     = !out_valid_reg || tx_ready;

    // Pick the byte at the current frame position
    always_comb
    begin
        sel_byte = PREAMBLE_BYTE;
        is_last  = 1'b0;
        is_body  = 1'b0;
        avail    = 1'b1;
        if (cmd.emit_kind == KIND_NACK)
        begin
            case (pos_reg)
                POS_PRE0, POS_PRE1: sel_byte = PREAMBLE_BYTE;
                POS_CTRL:           sel_byte = ctrl_addr_reg;
                POS_RIG:            sel_byte = radio_addr_reg;
                POS_CODE:           sel_byte = nack_code_reg;
                POS_NEND:
                begin
                    sel_byte = END_BYTE;
                    is_last  = 1'b1;
                end
                default:            sel_byte = END_BYTE;
            endcase
        end
        else
        begin
            if (pos_reg == POS_PRE0 || pos_reg == POS_PRE1)
                sel_byte = PREAMBLE_BYTE;
            else if (pos_reg == echo_end_pos)
            begin
                sel_byte = END_BYTE;
                is_last  = 1'b1;
            end
            else
            begin
                sel_byte = rd_data_reg;
                is_body  = 1'b1;
                avail    = rd_valid_reg;
            end
        end
    end

    assign load = cmd.emit_en && out_free && avail;

    assign status.is_preamble = (rx_byte == PREAMBLE_BYTE);
    assign status.is_end      = (rx_byte == END_BYTE);
    assign status.store_full  = (count_reg == CNT_W'(STORE_DEPTH));
    assign status.last_load   = load && is_last;

    // Write the body store and fetch the next body byte
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            mem[count_reg[IDX_W-1:0]] <= rx_byte;
        rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    // Track body count, read pointer and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.store_byte)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.start_emit)
            begin
                pos_reg      <= '0;
                rd_ptr_reg   <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (load)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (is_body)
                begin
                    rd_ptr_reg   <= rd_ptr_reg + CNT_W'(1);
                    rd_valid_reg <= 1'b0;
                end
                else
                    rd_valid_reg <= 1'b1;
            end
            else
                rd_valid_reg <= 1'b1;
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_addr_reg  <= CONTROLLER_ADDR_RST;
            radio_addr_reg <= RADIO_ADDR_RST;
            nack_code_reg  <= NACK_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTROLLER_ADDR: ctrl_addr_reg  <= cfg_data;
                CFG_RADIO_ADDR:      radio_addr_reg <= cfg_data;
                CFG_NACK_CODE:       nack_code_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Output register: load a byte when free, drop valid after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (tx_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= sel_byte;
            out_kind_reg <= cmd.emit_kind;
            out_len_reg  <= (cmd.emit_kind == KIND_NACK) ? '0 : len_masked;
            out_last_reg <= is_last;
        end
    end

    assign tx_valid    = out_valid_reg;
    assign tx_byte     = out_byte_reg;
    assign frame_kind  = out_kind_reg;
    assign body_length = out_len_reg;
    assign last_byte   = out_last_reg;

endmodule

`default_nettype wire

### hdl/cat_frame_receiver_echo_top.sv
// Top level of the serial command frame receiver with echo.
// Throughput: one received byte is taken per cycle while no frame is being sent.
// An echo or NACK is sent once the byte that ends the frame has been taken; in an echo each
// body byte after the first waits on the registered store read.
// Reset clears the receive state and loads the address and NACK code defaults.
`default_nettype none

module cat_frame_receiver_echo_top #(
    parameter int STORE_DEPTH = cfre_pkg::STORE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    cfre_cfg_if.sink   cfg,
    cfre_rx_if.sink    rx,
    cfre_tx_if.source  tx
);
    import cfre_pkg::*;

    cfre_cmd_t    cmd;
    cfre_status_t status;

    assign cfg.ready = 1'b1;

    cfre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfre_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx.rx_byte),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .status      (status),
        .tx_ready    (tx.ready),
        .tx_valid    (tx.valid),
        .tx_byte     (tx.tx_byte),
        .frame_kind  (tx.frame_kind),
        .body_length (tx.body_length),
        .last_byte   (tx.last_byte)
    );

endmodule

`default_nettype wire

### tb/sv/cat_frame_receiver_echo_top_tb.sv
// Self-checking testbench for the serial command frame receiver with echo.
`timescale 1ns / 1ps

module cat_frame_receiver_echo_top_tb;
    import cfre_pkg::*;

    localparam int STORE_DEPTH     = STORE_DEPTH_DEF;
    localparam int DIR_ROWS        = 25;
    localparam int PHASES          = 4;
    localparam int PHASE_ITEMS     = 12;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int DRAIN_TAIL      = 8;
    localparam int WATCHDOG_LIMIT  = 500;

    // Where the expected results of a transfer come from
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NACK_DEFAULT,
        CHK_EMPTY_ECHO
    } chk_e;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_SECOND,
        RX_BODY
    } rx_phase_e;

    typedef struct packed {
        byte_t            tx_byte;
        logic             frame_kind;
        logic [LEN_W-1:0] body_length;
        logic             last_byte;
    } tx_beat_t;

    typedef struct packed {
        byte_t rx_byte;
        chk_e  chk;
    } dir_row_t;

    // NACK with the reset register values, and the echo of an empty body
    localparam byte_t NACK_DEFAULT_FRAME [6] = '{PREAMBLE_BYTE, PREAMBLE_BYTE,
        CONTROLLER_ADDR_RST, RADIO_ADDR_RST, NACK_CODE_RST, END_BYTE};
    localparam byte_t EMPTY_ECHO_FRAME [3] = '{PREAMBLE_BYTE, PREAMBLE_BYTE, END_BYTE};

    localparam logic [CFG_IDX_W-1:0] CFG_REGS [3] = '{CFG_CONTROLLER_ADDR,
        CFG_RADIO_ADDR, CFG_NACK_CODE};

    // Noise, bad second preamble, empty body, preamble inside a full body, overflow
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'hFF, CHK_PREDICT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{8'h00, CHK_NACK_DEFAULT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{END_BYTE, CHK_EMPTY_ECHO},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{8'h00, CHK_PREDICT},
        '{8'hFF, CHK_PREDICT},
        '{8'h01, CHK_PREDICT},
        '{8'h80, CHK_PREDICT},
        '{8'h7F, CHK_PREDICT},
        '{8'hFC, CHK_PREDICT},
        '{8'h55, CHK_PREDICT},
        '{8'hAA, CHK_PREDICT},
        '{PREAMBLE_BYTE, CHK_PREDICT},
        '{8'h02, CHK_PREDICT},
        '{8'h04, CHK_PREDICT},
        '{8'h08, CHK_PREDICT},
        '{8'h10, CHK_PREDICT},
        '{8'h20, CHK_PREDICT},
        '{8'h40, CHK_PREDICT},
        '{8'hC3, CHK_NACK_DEFAULT}
    };

    logic clk;
    logic rst_n;

    cfre_cfg_if cfg_ch ();
    cfre_rx_if  rx_ch ();
    cfre_tx_if  tx_ch ();

    cat_frame_receiver_echo_top #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // Predictor state and register copies
    rx_phase_e rx_phase = RX_HUNT;
    int        body_cnt = 0;
    byte_t     body_mem [STORE_DEPTH];
    byte_t     ctrl_addr = CONTROLLER_ADDR_RST;
    byte_t     radio_addr = RADIO_ADDR_RST;
    byte_t     nack_val = NACK_CODE_RST;

    tx_beat_t  pred_beats [$];
    tx_beat_t  tx_frame_q [$];
    chk_e      rx_chk;
    int        mismatch_count = 0;
    bit        quiet = 1'b0;
    bit        hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic byte_t rand_body_byte();
        byte_t b;
        if ($urandom_range(0, 4) == 0)
            return PREAMBLE_BYTE;
        do
            b = byte_t'($urandom_range(0, 255));
        while (b == END_BYTE);
        return b;
    endfunction

    function automatic void add_beat(input byte_t b, input logic kind,
                                     input int len, input logic last);
        pred_beats.push_back(tx_beat_t'{b, kind, len[LEN_W-1:0], last});
    endfunction

    // Advance the receiver state by one byte and collect the bytes it sends
    function automatic void frame_rx_predict(input byte_t b);
        pred_beats.delete();
        case (rx_phase)
            RX_SECOND:
            begin
                if (b == PREAMBLE_BYTE)
                    rx_phase = RX_BODY;
                else
                begin
                    rx_phase = RX_HUNT;
                    body_cnt = 0;
                    add_beat(PREAMBLE_BYTE, KIND_NACK, 0, 1'b0);
                    add_beat(PREAMBLE_BYTE, KIND_NACK, 0, 1'b0);
                    add_beat(ctrl_addr, KIND_NACK, 0, 1'b0);
                    add_beat(radio_addr, KIND_NACK, 0, 1'b0);
                    add_beat(nack_val, KIND_NACK, 0, 1'b0);
                    add_beat(END_BYTE, KIND_NACK, 0, 1'b1);
                end
            end
            RX_BODY:
            begin
                if (b == END_BYTE)
                begin
                    add_beat(PREAMBLE_BYTE, KIND_ECHO, body_cnt, 1'b0);
                    add_beat(PREAMBLE_BYTE, KIND_ECHO, body_cnt, 1'b0);
                    for (int i = 0; i < body_cnt; i++)
                        add_beat(body_mem[i], KIND_ECHO, body_cnt, 1'b0);
                    add_beat(END_BYTE, KIND_ECHO, body_cnt, 1'b1);
                    rx_phase = RX_HUNT;
                    body_cnt = 0;
                end
                else if (body_cnt < STORE_DEPTH)
                begin
                    body_mem[body_cnt] = b;
                    body_cnt++;
                end
                else
                begin
                    rx_phase = RX_HUNT;
                    body_cnt = 0;
                    add_beat(PREAMBLE_BYTE, KIND_NACK, 0, 1'b0);
                    add_beat(PREAMBLE_BYTE, KIND_NACK, 0, 1'b0);
                    add_beat(ctrl_addr, KIND_NACK, 0, 1'b0);
                    add_beat(radio_addr, KIND_NACK, 0, 1'b0);
                    add_beat(nack_val, KIND_NACK, 0, 1'b0);
                    add_beat(END_BYTE, KIND_NACK, 0, 1'b1);
                end
            end
            default:
                rx_phase = (b == PREAMBLE_BYTE) ? RX_SECOND : RX_HUNT;
        endcase
    endfunction

    function automatic void cmp_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endfunction

    // Predict on every received byte transfer
    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            frame_rx_predict(rx_ch.rx_byte);
            case (rx_chk)
                CHK_NACK_DEFAULT:
                    foreach (NACK_DEFAULT_FRAME[i])
                        tx_frame_q.push_back(tx_beat_t'{NACK_DEFAULT_FRAME[i], KIND_NACK,
                            5'd0, i == $size(NACK_DEFAULT_FRAME) - 1});
                CHK_EMPTY_ECHO:
                    foreach (EMPTY_ECHO_FRAME[i])
                        tx_frame_q.push_back(tx_beat_t'{EMPTY_ECHO_FRAME[i], KIND_ECHO,
                            5'd0, i == $size(EMPTY_ECHO_FRAME) - 1});
                default:
                    foreach (pred_beats[i])
                        tx_frame_q.push_back(pred_beats[i]);
            endcase
        end
    end

    // Track register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            case (cfg_ch.index)
                CFG_CONTROLLER_ADDR: ctrl_addr = cfg_ch.data;
                CFG_RADIO_ADDR:      radio_addr = cfg_ch.data;
                CFG_NACK_CODE:       nack_val = cfg_ch.data;
                default:             ;
            endcase
    end

    // Compare each transmitted byte transfer with the oldest expectation
    always @(posedge clk)
    begin
        tx_beat_t exp_beat;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (tx_frame_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none, actual tx_byte %0h",
                         $time, tx_ch.tx_byte);
            end
            else
            begin
                exp_beat = tx_frame_q.pop_front();
                cmp_field("tx_byte", exp_beat.tx_byte, tx_ch.tx_byte);
                cmp_field("frame_kind", exp_beat.frame_kind, tx_ch.frame_kind);
                cmp_field("body_length", exp_beat.body_length, tx_ch.body_length);
                cmp_field("last_byte", exp_beat.last_byte, tx_ch.last_byte);
            end
        end
    end

    // Output back-pressure: random stalls plus one long hold-off on request
    initial
    begin : tx_ready_gen
        int stall;
        stall = 0;
        tx_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            else if (stall == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                tx_ch.ready <= 1'b0;
                stall--;
            end
            else
                tx_ch.ready <= 1'b1;
        end
    end

    // End the run when no channel makes progress for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one byte after a random gap and hold it until transferred
    task automatic send_byte(input byte_t b, input chk_e chk);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_chk        <= chk;
        forever
        begin
            @(posedge clk);
            if (rx_ch.ready)
                break;
        end
    endtask

    // Offer one register write and hold it until transferred
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
    endtask

    // Stop offering and wait for every expected byte, then let the block settle
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (tx_frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int    sent;
        int    pick;
        int    len;
        int    burst;
        bit    pressure_done;
        byte_t v;
        byte_t b;

        pressure_done = 1'b0;
        burst         = 0;
        rst_n         = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        rx_chk        <= CHK_PREDICT;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_CONTROLLER_ADDR;
        cfg_ch.data   <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with the reset register values
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].rx_byte, DIR_TABLE[i].chk);
        rx_chk <= CHK_PREDICT;
        drain();

        // Random frames under several register settings, extremes included
        for (int p = 0; p < PHASES; p++)
        begin
            foreach (CFG_REGS[r])
            begin
                case (p)
                    1:       v = 8'h00;
                    2:       v = 8'hFF;
                    default: v = byte_t'($urandom_range(0, 255));
                endcase
                write_reg(CFG_REGS[r], v);
            end
            cfg_ch.valid <= 1'b0;
            quiet = (p == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Hold off the output while full frames keep arriving back to back
                if (p == 0 && !pressure_done && sent >= 10)
                begin
                    pressure_done = 1'b1;
                    hold_off_req  = 1'b1;
                    quiet         = 1'b1;
                    burst         = 2;
                end
                pick = (burst > 0) ? 0 : $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = (burst > 0 || $urandom_range(0, 9) == 0) ?
                          STORE_DEPTH : $urandom_range(0, STORE_DEPTH - 1);
                    send_byte(PREAMBLE_BYTE, CHK_PREDICT);
                    send_byte(PREAMBLE_BYTE, CHK_PREDICT);
                    repeat (len) send_byte(rand_body_byte(), CHK_PREDICT);
                    send_byte(END_BYTE, CHK_PREDICT);
                    sent += len + 3;
                end
                else if (pick < 80)
                begin
                    send_byte(PREAMBLE_BYTE, CHK_PREDICT);
                    send_byte(PREAMBLE_BYTE, CHK_PREDICT);
                    repeat (STORE_DEPTH + 1) send_byte(rand_body_byte(), CHK_PREDICT);
                    sent += STORE_DEPTH + 3;
                end
                else if (pick < 90)
                begin
                    do
                        b = byte_t'($urandom_range(0, 255));
                    while (b == PREAMBLE_BYTE);
                    send_byte(PREAMBLE_BYTE, CHK_PREDICT);
                    send_byte(b, CHK_PREDICT);
                    sent += 2;
                end
                else
                begin
                    do
                        b = byte_t'($urandom_range(0, 255));
                    while (b == PREAMBLE_BYTE);
                    send_byte(b, CHK_PREDICT);
                    sent += 1;
                end
                if (burst > 0)
                begin
                    burst--;
                    if (burst == 0)
                        quiet = (p == 2);
                end
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### cat_frame_receiver_echo_top.f
hdl/cfre_pkg.sv
hdl/cfre_if.sv
hdl/cfre_ctrl.sv
hdl/cfre_datapath.sv
hdl/cat_frame_receiver_echo_top.sv
tb/sv/cat_frame_receiver_echo_top_tb.sv
